// ===== hw/rtl/ffha_pkg.sv =====
package ffha_pkg;

  localparam int GRANULE_BYTES = 16;
  localparam int HEADER_BYTES  = 32;
  localparam int PAGE_BYTES    = 4096;
  localparam int MAX_PAGES     = 16;

  localparam int HDR_G       = HEADER_BYTES / GRANULE_BYTES;
  localparam int PAGE_G      = PAGE_BYTES / GRANULE_BYTES;
  localparam int TABLE_DEPTH = MAX_PAGES * PAGE_G;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int SIZE_W      = 14;
  localparam int POS_W       = SIZE_W + 1;
  localparam int PAGE_W      = 5;
  localparam int GRAN_SHIFT  = $clog2(GRANULE_BYTES);
  localparam int PAGE_SHIFT  = $clog2(PAGE_G);

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NULL = 2'd1;
  localparam logic [1:0] ST_OOM  = 2'd2;
  localparam logic [1:0] ST_BAD  = 2'd3;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef struct packed {
    logic        action;
    logic [15:0] request_bytes;
    logic [15:0] release_address;
  } in_item_t;

  typedef struct packed {
    logic [15:0] payload_address;
    logic [1:0]  status;
  } out_item_t;

  // One table word: start-of-block flag, payload size in granules, free flag.
  typedef struct packed {
    logic              start;
    logic [SIZE_W-1:0] size;
    logic              free;
  } entry_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    entry_t            wdata;
  } mem_req_t;

endpackage

// ===== hw/rtl/first_fit_heap_allocator.sv =====
// First-fit heap allocator with coalescing.
//
// The input channel (in_valid, in_stall, in_data) carries one transaction per
// request: an allocate of request_bytes or a free of release_address. The
// output channel (out_valid, out_stall, out_data) returns exactly one
// transaction per request with the payload offset and a status code.
// cfg_wen/cfg_wdata write the page limit; write it only while the block is idle (not enforced).
//
// Requests are handled one at a time. The accepting cycle decodes the request.
// An allocate walks the block list, reading and then checking each block it
// visits, then grants the block, splitting it first when the remainder is big
// enough. Running off the end grows the arena, and the walk then restarts from
// the first block. A free reads, checks and marks the block, then walks the
// whole list to merge: it reads and checks each block, reads the successor of
// a free block, and writes each merged pair, after which the merged block is
// visited again. All of it is bounded by the single port of the block table.
// The result is registered in the cycle after the last step, so a zero size or
// a null free passes from decode through the final state to the output register.
//
// After reset the table is swept to clear every start flag, one entry per
// cycle, over all 4096 entries; in_stall stays high meanwhile. A stalled
// result is held in the output register and the next request waits for it.
module first_fit_heap_allocator (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ffha_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ffha_pkg::out_item_t  out_data,
  input  logic                 cfg_wen,
  input  logic [4:0]           cfg_wdata
);

  typedef enum logic [4:0] {
    CLEAR, IDLE,
    S_RD, S_CHK, S_SPLIT, S_TAKE, S_GROW,
    F_RD, F_CHK, F_MARK,
    M_RD, M_CHK, M_RDN, M_CHKN, M_WRP, M_WRN,
    FIN
  } state_t;

  localparam int AW = ffha_pkg::ADDR_W;
  localparam int SW = ffha_pkg::SIZE_W;
  localparam int PW = ffha_pkg::POS_W;

  state_t                    state;
  logic [AW-1:0]             clr_cnt;
  logic [4:0]                page_limit;
  logic [ffha_pkg::PAGE_W-1:0] end_pages;
  logic [PW-1:0]             pos;
  logic [PW-1:0]             nxt;
  logic [SW-1:0]             want;
  logic [SW-1:0]             take_size;
  logic [SW-1:0]             split_size;
  logic [SW-1:0]             cur_size;
  logic                      grown;
  logic [15:0]               res_pay;
  logic [1:0]                res_st;

  ffha_pkg::mem_req_t        req;
  ffha_pkg::entry_t          rdata;

  ffha_table u_table (.clk(clk), .req(req), .rdata(rdata));

  // Arena end in granules.
  logic [PW-1:0] end_g;
  assign end_g = PW'({end_pages, {ffha_pkg::PAGE_SHIFT{1'b0}}});

  // The one shared adder: position plus header plus a block size.
  logic [SW-1:0] add_b;
  logic [PW-1:0] step_sum;
  always_comb begin
    unique case (state)
      S_SPLIT: add_b = want;
      default: add_b = rdata.size;
    endcase
  end
  assign step_sum = pos + PW'(ffha_pkg::HDR_G) + PW'(add_b);

  // Request decode.
  logic [16:0]   req_round;
  logic [SW-1:0] want_in;
  logic [15:0]   rel_off;
  logic [PW-1:0] rel_pos;
  assign req_round = {1'b0, in_data.request_bytes} + 17'(ffha_pkg::GRANULE_BYTES - 1);
  assign want_in   = SW'(req_round >> ffha_pkg::GRAN_SHIFT);
  assign rel_off   = in_data.release_address - 16'(ffha_pkg::HEADER_BYTES);
  assign rel_pos   = PW'(rel_off >> ffha_pkg::GRAN_SHIFT);

  // Growth: whole pages that hold the request plus a header.
  logic [SW-1:0] grow_sum;
  logic [5:0]    grow_pages;
  logic [6:0]    pages_after;
  logic [4:0]    eff_limit;
  assign grow_sum    = want + SW'(ffha_pkg::HDR_G + ffha_pkg::PAGE_G - 1);
  assign grow_pages  = 6'(grow_sum >> ffha_pkg::PAGE_SHIFT);
  assign pages_after = 7'(end_pages) + 7'(grow_pages);
  assign eff_limit   = (page_limit < 5'(ffha_pkg::MAX_PAGES)) ? page_limit
                                                              : 5'(ffha_pkg::MAX_PAGES);

  logic [SW-1:0] diff;
  assign diff = rdata.size - want;

  logic out_free;
  assign out_free = !out_valid || !out_stall;

  assign in_stall = (state != IDLE) || out_valid;

  always_comb begin
    req = '0;
    req.addr = pos[AW-1:0];
    unique case (state)
      CLEAR: begin
        req.we   = 1'b1;
        req.addr = clr_cnt;
      end
      S_SPLIT: begin
        req.we    = 1'b1;
        req.addr  = step_sum[AW-1:0];
        req.wdata = '{start: 1'b1, size: split_size, free: 1'b1};
      end
      S_TAKE: begin
        req.we    = 1'b1;
        req.wdata = '{start: 1'b1, size: take_size, free: 1'b0};
      end
      S_GROW: begin
        req.we    = (pages_after <= 7'(eff_limit));
        req.addr  = end_g[AW-1:0];
        req.wdata = '{start: 1'b1,
                      size: SW'({grow_pages, {ffha_pkg::PAGE_SHIFT{1'b0}}})
                            - SW'(ffha_pkg::HDR_G),
                      free: 1'b1};
      end
      F_MARK: begin
        req.we    = 1'b1;
        req.wdata = '{start: 1'b1, size: cur_size, free: 1'b1};
      end
      M_RDN: req.addr = nxt[AW-1:0];
      M_WRP: begin
        req.we    = 1'b1;
        req.wdata = '{start: 1'b1,
                      size: cur_size + SW'(ffha_pkg::HDR_G) + take_size,
                      free: 1'b1};
      end
      M_WRN: begin
        req.we   = 1'b1;
        req.addr = nxt[AW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= CLEAR;
      clr_cnt    <= '0;
      end_pages  <= '0;
      page_limit <= 5'd16;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wen) begin
        page_limit <= cfg_wdata;
      end
      // The output register loads from the final state and empties on a
      // transaction otherwise.
      if (state == FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (&clr_cnt) begin
            state <= IDLE;
          end
        end
        IDLE: begin
          if (in_valid && !in_stall) begin
            res_pay <= '0;
            grown   <= 1'b0;
            want    <= want_in;
            pos     <= (in_data.action == ffha_pkg::ACT_FREE) ? rel_pos : '0;
            if (in_data.action == ffha_pkg::ACT_ALLOC) begin
              if (in_data.request_bytes == '0) begin
                res_st <= ffha_pkg::ST_NULL;
                state  <= FIN;
              end else begin
                res_st <= ffha_pkg::ST_OK;
                state  <= S_RD;
              end
            end else begin
              priority if (in_data.release_address == '0) begin
                res_st <= ffha_pkg::ST_NULL;
                state  <= FIN;
              end else if (in_data.release_address < 16'(ffha_pkg::HEADER_BYTES)
                           || rel_off[ffha_pkg::GRAN_SHIFT-1:0] != '0
                           || rel_pos >= end_g) begin
                res_st <= ffha_pkg::ST_BAD;
                state  <= FIN;
              end else begin
                res_st <= ffha_pkg::ST_OK;
                state  <= F_RD;
              end
            end
          end
        end
        S_RD: begin
          if (pos >= end_g) begin
            state <= grown ? FIN : S_GROW;
            if (grown) begin
              res_st <= ffha_pkg::ST_OOM;
            end
          end else begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (rdata.free && rdata.size >= want) begin
            // Split only when the remainder holds a header and a granule.
            if (diff >= SW'(ffha_pkg::HDR_G + 1)) begin
              split_size <= diff - SW'(ffha_pkg::HDR_G);
              take_size  <= want;
              state      <= S_SPLIT;
            end else begin
              take_size <= rdata.size;
              state     <= S_TAKE;
            end
          end else begin
            pos   <= step_sum;
            state <= S_RD;
          end
        end
        S_SPLIT: state <= S_TAKE;
        S_TAKE: begin
          res_pay <= 16'(pos[AW-1:0] * ffha_pkg::GRANULE_BYTES)
                     + 16'(ffha_pkg::HEADER_BYTES);
          state   <= FIN;
        end
        S_GROW: begin
          if (pages_after <= 7'(eff_limit)) begin
            end_pages <= ffha_pkg::PAGE_W'(pages_after);
            grown     <= 1'b1;
            pos       <= '0;
            state     <= S_RD;
          end else begin
            res_st <= ffha_pkg::ST_OOM;
            state  <= FIN;
          end
        end
        F_RD: state <= F_CHK;
        F_CHK: begin
          cur_size <= rdata.size;
          if (!rdata.start) begin
            res_st <= ffha_pkg::ST_BAD;
            state  <= FIN;
          end else begin
            state <= F_MARK;
          end
        end
        F_MARK: begin
          pos   <= '0;
          state <= M_RD;
        end
        M_RD: state <= (pos >= end_g) ? FIN : M_CHK;
        M_CHK: begin
          cur_size <= rdata.size;
          nxt      <= step_sum;
          if (rdata.free && step_sum < end_g) begin
            state <= M_RDN;
          end else begin
            pos   <= step_sum;
            state <= M_RD;
          end
        end
        M_RDN: state <= M_CHKN;
        M_CHKN: begin
          take_size <= rdata.size;
          if (rdata.free) begin
            state <= M_WRP;
          end else begin
            pos   <= nxt;
            state <= M_RD;
          end
        end
        M_WRP: state <= M_WRN;
        M_WRN: state <= M_RD;
        FIN: begin
          if (out_free) begin
            out_data.payload_address <= res_pay;
            out_data.status          <= res_st;
            state                    <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/ffha_table.sv =====
module ffha_table (
  input  logic              clk,
  input  ffha_pkg::mem_req_t req,
  output ffha_pkg::entry_t   rdata
);

  ffha_pkg::entry_t mem [ffha_pkg::TABLE_DEPTH];

  // Single port: a cycle either writes or reads the addressed word.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end else begin
      rdata <= mem[req.addr];
    end
  end

endmodule

// ===== hw/rtl/ffha_checker.sv =====
module ffha_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input ffha_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while one is in progress");

  a_fail_no_address: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ffha_pkg::ST_OK |-> out_data.payload_address == '0)
    else $error("failing result carries an address");

  a_address_aligned: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.payload_address != '0
      |-> out_data.payload_address[3:0] == 4'd0 && out_data.status == ffha_pkg::ST_OK)
    else $error("granted address is misaligned");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
